// File: rtl/core/pvn3_pkg.sv
// Package: constants and helpers for the periodic value noise block.
package pvn3_pkg;
	localparam int PeriodBitsDef = 8;
	localparam int FracBitsDef = 16;
	localparam logic [7:0] PeriodAroundRst = 8'd8;
	localparam logic [31:0] HashKx = 32'd374761393;
	localparam logic [31:0] HashKy = 32'd668265263;
	localparam logic [31:0] HashKz = 32'd2147483647;
	localparam logic [31:0] HashKm = 32'd1274126177;
	localparam logic [23:0] H24 = 24'hFFFFFF;
endpackage

// File: rtl/core/periodic_value_noise_3d.sv
// Top level: pipelined periodic 3D value noise with quintic fade.
//
// channel  | handshake          | payload
// cfg      | cfg_valid/ready    | cfg_data (period_around)
// in       | start & !busy      | coord_u, coord_v, coord_w, period_along
// out      | done strobe        | noise_value
//
// One item per cycle; done is the start bit carried along a valid shift register.
// The depth is set by the four-stage remainder unit for the cell wrap, the
// multiply chains of the fade and hash and the three lerp levels. busy is
// always low; the receiver cannot stall, so the pipeline never halts.
// Reset clears valid bits and sets period_around to 8.
module periodic_value_noise_3d
	import pvn3_pkg::*;
#(
	parameter int PERIOD_BITS = PeriodBitsDef,
	parameter int FRAC_BITS = FracBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [PERIOD_BITS-1:0] cfg_data,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [23:0]     coord_u,
	input  logic signed [23:0]     coord_v,
	input  logic signed [31:0]     coord_w,
	input  logic [7:0]             period_along,
	output logic                   done,
	output logic [15:0]            noise_value
);
	localparam int PB = PERIOD_BITS;
	localparam int SW = 24 + PB + 1;      // scaled product width
	localparam int IW = SW - FRAC_BITS;   // floor width
	localparam int NS = 12;

	logic [PB-1:0] period_around_q;
	logic [NS:1] vld;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;
	assign done = vld[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_around_q <= PB'(PeriodAroundRst);
			vld <= '0;
		end else begin
			if (cfg_valid) period_around_q <= cfg_data;
			vld <= {vld[NS-1:1], start};
		end
	end

	function automatic logic [31:0] hmix(input logic [31:0] h);
		return h ^ (h >> 13);
	endfunction

	// s1: scale
	logic signed [SW-1:0] xs_s1, ys_s1;
	logic signed [31:0] w_s1;
	logic [PB-1:0] pu_s1, pv_s1;
	logic [PB-1:0] pu_c, pv_c, pa_c;
	assign pa_c = PB'(period_along);
	assign pu_c = (period_around_q == '0) ? PB'(1) : period_around_q;
	assign pv_c = (pa_c == '0) ? PB'(1) : pa_c;

	always_ff @(posedge clk) begin
		xs_s1 <= SW'(coord_u) * $signed({1'b0, pu_c});
		ys_s1 <= SW'(coord_v) * $signed({1'b0, pv_c});
		w_s1 <= coord_w;
		pu_s1 <= pu_c;
		pv_s1 <= pv_c;
	end

	// s2: floor and Q0.16 fractions
	logic signed [IW-1:0] fx_fl, fy_fl;
	logic [15:0] tx_c, ty_c, tz_c;
	assign fx_fl = IW'(xs_s1 >>> FRAC_BITS);
	assign fy_fl = IW'(ys_s1 >>> FRAC_BITS);
	always_comb begin
		logic [FRAC_BITS-1:0] a, b, c;
		a = xs_s1[FRAC_BITS-1:0];
		b = ys_s1[FRAC_BITS-1:0];
		c = w_s1[FRAC_BITS-1:0];
		tx_c = 16'(({a, 16'd0}) >> FRAC_BITS);
		ty_c = 16'(({b, 16'd0}) >> FRAC_BITS);
		tz_c = 16'(({c, 16'd0}) >> FRAC_BITS);
	end
	logic [PB-1:0] pu_s2, pv_s2;
	logic [15:0] tx_s2, ty_s2, tz_s2;
	logic signed [IW-1:0] xf_s2, yf_s2;
	logic signed [31:0] z0_s2;
	always_ff @(posedge clk) begin
		xf_s2 <= fx_fl;
		yf_s2 <= fy_fl;
		pu_s2 <= pu_s1;
		pv_s2 <= pv_s1;
		tx_s2 <= tx_c;
		ty_s2 <= ty_c;
		tz_s2 <= tz_c;
		z0_s2 <= w_s1 >>> FRAC_BITS;
	end

	// Wrap the u and v floor indices: restoring remainder of |floor| by the
	// period, up to (IW+3)/4 steps per stage over four stages.
	localparam int DSTEPS = IW;
	localparam int PER = (DSTEPS + 3) / 4;
	typedef struct packed {
		logic [IW-1:0] num;
		logic [PB:0]   rem;
	} div_t;
	div_t dx [0:4], dy [0:4];
	logic [PB-1:0] pu_d [0:4], pv_d [0:4];
	logic [15:0] tx_d [0:4], ty_d [0:4], tz_d [0:4];
	logic signed [31:0] z_d [0:4];

	// take |n| here, fold the sign back in after the remainder
	logic negx [0:4], negy [0:4];
	always_comb begin
		dx[0].num = xf_s2[IW-1] ? IW'(-xf_s2) : xf_s2;
		dy[0].num = yf_s2[IW-1] ? IW'(-yf_s2) : yf_s2;
		dx[0].rem = '0;
		dy[0].rem = '0;
		negx[0] = xf_s2[IW-1];
		negy[0] = yf_s2[IW-1];
		pu_d[0] = pu_s2;
		pv_d[0] = pv_s2;
		tx_d[0] = tx_s2;
		ty_d[0] = ty_s2;
		tz_d[0] = tz_s2;
		z_d[0] = z0_s2;
	end

	function automatic div_t dstep(input div_t d, input logic [PB-1:0] p);
		logic [PB+1:0] r;
		div_t o;
		r = {d.rem, d.num[IW-1]};
		o.num = d.num << 1;
		o.rem = (r >= {2'b0, p}) ? (PB+1)'(r - {2'b0, p}) : r[PB:0];
		return o;
	endfunction

	for (genvar g = 0; g < 4; g++) begin : g_div
		div_t nx, ny;
		always_comb begin
			nx = dx[g];
			ny = dy[g];
			for (int k = 0; k < PER; k++) begin
				if (g * PER + k < DSTEPS) begin
					nx = dstep(nx, pu_d[g]);
					ny = dstep(ny, pv_d[g]);
				end
			end
		end
		always_ff @(posedge clk) begin
			dx[g+1] <= nx;
			dy[g+1] <= ny;
			negx[g+1] <= negx[g];
			negy[g+1] <= negy[g];
			pu_d[g+1] <= pu_d[g];
			pv_d[g+1] <= pv_d[g];
			tx_d[g+1] <= tx_d[g];
			ty_d[g+1] <= ty_d[g];
			tz_d[g+1] <= tz_d[g];
			z_d[g+1] <= z_d[g];
		end
	end

	// s7: corners and fade part 1
	logic [PB-1:0] rx, ry, x0_c, y0_c, x1_c, y1_c;
	assign rx = dx[4].rem[PB-1:0];
	assign ry = dy[4].rem[PB-1:0];
	assign x0_c = (negx[4] && rx != '0) ? pu_d[4] - rx : rx;
	assign y0_c = (negy[4] && ry != '0) ? pv_d[4] - ry : ry;
	assign x1_c = (x0_c + PB'(1) == pu_d[4]) ? '0 : x0_c + PB'(1);
	assign y1_c = (y0_c + PB'(1) == pv_d[4]) ? '0 : y0_c + PB'(1);

	logic [31:0] hx_s7 [0:1], hy_s7 [0:1], hz_s7 [0:1];
	logic [31:0] tt_s7 [0:2];
	logic [15:0] t_s7 [0:2];
	always_ff @(posedge clk) begin
		hx_s7[0] <= 32'(x0_c) * HashKx;
		hx_s7[1] <= 32'(x1_c) * HashKx;
		hy_s7[0] <= 32'(y0_c) * HashKy;
		hy_s7[1] <= 32'(y1_c) * HashKy;
		hz_s7[0] <= 32'(z_d[4]) * HashKz;
		hz_s7[1] <= 32'(z_d[4] + 32'sd1) * HashKz;
		tt_s7[0] <= 32'(tx_d[4]) * 32'(tx_d[4]);
		tt_s7[1] <= 32'(ty_d[4]) * 32'(ty_d[4]);
		tt_s7[2] <= 32'(tz_d[4]) * 32'(tz_d[4]);
		t_s7[0] <= tx_d[4];
		t_s7[1] <= ty_d[4];
		t_s7[2] <= tz_d[4];
	end

	// s8: hash sum + mix multiply; fade g and t3
	logic [23:0] hv_s8 [0:7];
	logic [31:0] hm_c [0:7];
	logic [31:0] hp_s8 [0:7];
	logic [19:0] gh_s8 [0:2];
	logic [31:0] t3_s8 [0:2];
	always_comb begin
		for (int c = 0; c < 8; c++)
			hm_c[c] = hmix(hx_s7[c[0]] + hy_s7[c[1]] + hz_s7[c[2]]);
	end
	always_ff @(posedge clk) begin
		for (int c = 0; c < 8; c++) hp_s8[c] <= hm_c[c] * HashKm;
		for (int i = 0; i < 3; i++) begin
			// g >> 16 spans 2^16 up to 10 * 2^16
			gh_s8[i] <= 20'(((36'd10 << 32) - 36'd983040 * 36'(t_s7[i])
				+ 36'd6 * 36'(tt_s7[i])) >> 16);
			t3_s8[i] <= 32'((48'(tt_s7[i]) * 48'(t_s7[i])) >> 16);
		end
	end
	always_comb for (int c = 0; c < 8; c++) hv_s8[c] = 24'(hp_s8[c] ^ (hp_s8[c] >> 16));

	// s9: fade result; s10: lerp along u
	logic [16:0] f_c [0:2];
	always_comb for (int i = 0; i < 3; i++)
		f_c[i] = 17'((48'(t3_s8[i]) * 48'(gh_s8[i])) >> 32);
	logic [23:0] hv_s9 [0:7];
	logic [16:0] f_s9 [0:2];
	always_ff @(posedge clk) begin
		hv_s9 <= hv_s8;
		f_s9 <= f_c;
	end

	function automatic logic [23:0] lerp(input logic [23:0] a, input logic [23:0] b,
		input logic [16:0] f);
		return 24'((41'(a) * 41'(17'h10000 - f) + 41'(b) * 41'(f)) >> 16);
	endfunction

	logic [23:0] l1_s10 [0:3];
	logic [16:0] fy_s10, fz_s10;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++)
			l1_s10[k] <= lerp(hv_s9[2*k], hv_s9[2*k+1], f_s9[0]);
		fy_s10 <= f_s9[1];
		fz_s10 <= f_s9[2];
	end

	// s11: v lerps
	logic [23:0] c0_s11, c1_s11;
	logic [16:0] fz_s11;
	always_ff @(posedge clk) begin
		c0_s11 <= lerp(l1_s10[0], l1_s10[1], fy_s10);
		c1_s11 <= lerp(l1_s10[2], l1_s10[3], fy_s10);
		fz_s11 <= fz_s10;
	end

	// s12: w lerp, scale to 16 bits
	logic [23:0] r_c;
	logic [39:0] sc_c;
	assign r_c = lerp(c0_s11, c1_s11, fz_s11);
	// (r*65535 + 0x7FFFFF)/0xFFFFFF: n/(2^24-1) = (n + (n>>24) + 1) >> 24 for n < 2^40
	always_comb begin
		logic [41:0] n;
		n = 42'(r_c) * 42'd65535 + 42'h7FFFFF;
		sc_c = 40'((n + (n >> 24) + 42'd1) >> 24);
	end
	always_ff @(posedge clk) noise_value <= sc_c[15:0];
endmodule

// File: rtl/core/pvn3_checker.sv
// Checker: port-level properties of the noise block, bound to the top.
module pvn3_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##12 done) else $error("result missing");
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 12)) else $error("spurious result");
endmodule

bind periodic_value_noise_3d pvn3_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done));
